FILE: src/signed_integer_divider_defines.svh
// assertion macros for the signed integer divider
`ifndef SIGNED_INTEGER_DIVIDER_DEFINES_SVH
`define SIGNED_INTEGER_DIVIDER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define SID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define SID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/sid_pkg.sv
`timescale 1ns / 1ps

package sid_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MAX_POS  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};
  localparam logic [DATA_WIDTH-1:0] ONE      = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator;
    logic signed [DATA_WIDTH-1:0] denominator;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quotient;
    logic                         overflow_flag;
    logic                         zero_divisor_flag;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic logic [DATA_WIDTH-1:0] negate(input logic [DATA_WIDTH-1:0] v);
    negate = (~v) + ONE;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
    magnitude = v[DATA_WIDTH-1] ? negate(v) : v;
  endfunction

endpackage

FILE: src/sid_core.sv
`timescale 1ns / 1ps

module sid_core
  import sid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] n_mag,
  input  logic [DATA_WIDTH-1:0] d_mag,
  output core_stat_t            stat,
  output logic [DATA_WIDTH-1:0] quot
);

  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] num_r, num_nxt;
  logic [DATA_WIDTH-1:0] den_r, den_nxt;
  logic [DATA_WIDTH-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DATA_WIDTH-1:0] shifted;
  logic                  ge;

  // one quotient bit per cycle, dividend shifted in from the top
  assign shifted = {rem_r[DATA_WIDTH-2:0], num_r[DATA_WIDTH-1]};
  assign ge      = (shifted >= den_r);

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      num_nxt  = n_mag;
      den_nxt  = d_mag;
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(DATA_WIDTH - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? (shifted - den_r) : shifted;
      num_nxt = {num_r[DATA_WIDTH-2:0], 1'b0};
      q_nxt   = {q_r[DATA_WIDTH-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

FILE: src/signed_integer_divider.sv
`timescale 1ns / 1ps

// channel  ports                        word
// input    in_valid / in_ready          in_word  (numerator, denominator)
// output   out_valid / out_ready        out_word (quotient, overflow_flag, zero_divisor_flag)
//
// a normal word goes from accept through the shift-subtract core, one quotient bit per
// cycle, and then through the sign fix into the output register.
// zero divisor and most-negative by minus one skip the core and go straight to the sign fix.
// one word is in work at a time; a new word is taken while a result waits in out_word.
// a stalled output holds the finished result in the core until the output register frees.
// synchronous active-low reset clears the control state only.

module signed_integer_divider
  import sid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic        neg_r, neg_nxt;
  logic        ovf_r, ovf_nxt;
  logic        dz_r, dz_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic                  accept;
  logic                  start;
  logic                  is_dz;
  logic                  is_ovf;
  logic [DATA_WIDTH-1:0] n_raw;
  logic [DATA_WIDTH-1:0] d_raw;
  logic [DATA_WIDTH-1:0] quot;
  logic                  slot_free;
  core_stat_t            stat;

  assign n_raw     = in_word.numerator;
  assign d_raw     = in_word.denominator;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_dz     = (d_raw == '0);
  assign is_ovf    = (n_raw == MOST_NEG) && (d_raw == ALL_ONES);
  assign start     = accept && !is_dz && !is_ovf;
  assign slot_free = !out_valid_r || out_ready;

  sid_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .n_mag (magnitude(n_raw)),
    .d_mag (magnitude(d_raw)),
    .stat  (stat),
    .quot  (quot)
  );

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    ovf_nxt       = ovf_r;
    dz_nxt        = dz_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt   = n_raw[DATA_WIDTH-1] ^ d_raw[DATA_WIDTH-1];
          ovf_nxt   = is_ovf;
          dz_nxt    = is_dz;
          state_nxt = start ? ST_RUN : ST_FIN;
        end
      end
      ST_RUN: begin
        if (stat.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt                  = 1'b1;
          out_word_nxt.overflow_flag     = ovf_r;
          out_word_nxt.zero_divisor_flag = dz_r;
          if (dz_r) begin
            out_word_nxt.quotient = '0;
          end else if (ovf_r) begin
            out_word_nxt.quotient = MAX_POS;
          end else begin
            out_word_nxt.quotient = neg_r ? negate(quot) : quot;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    ovf_r      <= ovf_nxt;
    dz_r       <= dz_nxt;
    out_word_r <= out_word_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: src/sid_checker.sv
`timescale 1ns / 1ps
`include "signed_integer_divider_defines.svh"

module sid_checker
  import sid_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  `SID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "output word changed while stalled")
  `SID_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "new word taken while one is in work")
  `SID_ASSERT_NOW(a_flags_exclusive, out_valid, !(out_word.overflow_flag && out_word.zero_divisor_flag), "both flags set")
  `SID_ASSERT_NOW(a_dz_quotient, out_valid && out_word.zero_divisor_flag, out_word.quotient == '0, "zero divisor quotient not zero")
  `SID_ASSERT_NOW(a_ovf_quotient, out_valid && out_word.overflow_flag, out_word.quotient == MAX_POS, "overflow quotient not saturated")

endmodule

bind signed_integer_divider sid_checker u_sid_checker (.*);
